>>> rtl/mpsa_pkg.sv
// Shared types and constants for the multi-pool slot allocator.
package mpsa_pkg;

    localparam int NUM_POOLS_DEF = 8;
    localparam int SLOTS_DEF     = 32;
    localparam int OP_W          = 2;
    localparam int SIZE_W        = 16;
    localparam int OFFS_W        = 21;
    localparam int STAT_W        = 3;

    typedef enum logic [OP_W-1:0] {
        OP_CREATE  = 2'd0,
        OP_ALLOC   = 2'd1,
        OP_FREE    = 2'd2,
        OP_DESTROY = 2'd3
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK         = 3'd0,
        ST_BAD_SIZE   = 3'd1,
        ST_NO_POOL    = 3'd2,
        ST_BAD_ARG    = 3'd3,
        ST_POOL_FULL  = 3'd4,
        ST_TABLE_FULL = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_DIVIDE,
        S_EXEC,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the input word
        logic lookup;    // register the pool match and free-entry search
        logic div_start; // start the offset divider
        logic exec;      // apply the operation and register the result
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_free;   // the captured word is a free with a matching pool
        logic div_done;
    } t_sts;

endpackage

>>> rtl/mpsa_div.sv
// Restoring divider that yields one quotient bit a cycle.
module mpsa_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [mpsa_pkg::OFFS_W-1:0] i_dividend,
    input  logic [mpsa_pkg::SIZE_W-1:0] i_divisor,
    output logic                        o_done,
    output logic [mpsa_pkg::OFFS_W-1:0] o_quot,
    output logic [mpsa_pkg::SIZE_W-1:0] o_rem
);
    import mpsa_pkg::*;

    localparam int CNT_W = $clog2(OFFS_W + 1);

    logic [OFFS_W-1:0] r_quot, n_quot;
    logic [SIZE_W:0]   r_rem, n_rem;
    logic [SIZE_W-1:0] r_dsr;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [SIZE_W+1:0] w_trial;

    // One shift and trial subtract per step.
    always_comb begin
        n_quot  = r_quot;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        w_trial = {r_rem, r_quot[OFFS_W-1]} - {2'b00, r_dsr};
        if (i_start) begin
            n_quot = i_dividend;
            n_rem  = '0;
            n_cnt  = CNT_W'(OFFS_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_trial[SIZE_W+1]) begin
                n_rem = {r_rem[SIZE_W-1:0], r_quot[OFFS_W-1]};
                n_quot = {r_quot[OFFS_W-2:0], 1'b0};
            end else begin
                n_rem = w_trial[SIZE_W:0];
                n_quot = {r_quot[OFFS_W-2:0], 1'b1};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        if (i_start) begin
            r_dsr <= i_divisor;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem[SIZE_W-1:0];

endmodule

>>> rtl/mpsa_datapath.sv
// Pool table, slot bitmaps and operation logic for the allocator.
module mpsa_datapath #(
    parameter int NUM_POOLS = mpsa_pkg::NUM_POOLS_DEF,
    parameter int SLOTS     = mpsa_pkg::SLOTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mpsa_pkg::t_cmd              i_cmd,
    output mpsa_pkg::t_sts              o_sts,
    input  logic [mpsa_pkg::OP_W-1:0]   i_op,
    input  logic [mpsa_pkg::SIZE_W-1:0] i_obj_size,
    input  logic [mpsa_pkg::OFFS_W-1:0] i_offset,
    output logic [mpsa_pkg::STAT_W-1:0] o_status,
    output logic [mpsa_pkg::OFFS_W-1:0] o_alloc_offset
);
    import mpsa_pkg::*;

    localparam int PI_W = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
    localparam int SI_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [NUM_POOLS-1:0] r_valid;
    logic [SIZE_W-1:0]    r_bytes [NUM_POOLS];
    logic [SLOTS-1:0]     r_map   [NUM_POOLS];

    t_op               r_op;
    logic [SIZE_W-1:0] r_size;
    logic [OFFS_W-1:0] r_offs;

    logic              r_hit;
    logic [PI_W-1:0]   r_hit_idx;
    logic              r_has_free;
    logic [PI_W-1:0]   r_free_idx;
    logic [SLOTS-1:0]  r_pmap;

    logic              w_hit;
    logic [PI_W-1:0]   w_hit_idx;
    logic              w_has_free;
    logic [PI_W-1:0]   w_free_idx;

    logic              w_div_done;
    logic [OFFS_W-1:0] w_quot;
    logic [SIZE_W-1:0] w_rem;

    logic              w_slot_any;
    logic [SI_W-1:0]   w_slot;

    logic [STAT_W-1:0] r_status;
    logic [OFFS_W-1:0] r_aoffs;

    // Capture the input word.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= t_op'(i_op);
            r_size <= i_obj_size;
            r_offs <= i_offset;
        end
    end

    // Pool match and lowest free entry.
    always_comb begin
        w_hit      = 1'b0;
        w_hit_idx  = '0;
        w_has_free = 1'b0;
        w_free_idx = '0;
        for (int i = NUM_POOLS - 1; i >= 0; i--) begin
            if (r_valid[i] && r_bytes[i] == r_size) begin
                w_hit     = 1'b1;
                w_hit_idx = PI_W'(i);
            end
            if (!r_valid[i]) begin
                w_has_free = 1'b1;
                w_free_idx = PI_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_hit      <= w_hit;
            r_hit_idx  <= w_hit_idx;
            r_has_free <= w_has_free;
            r_free_idx <= w_free_idx;
            r_pmap     <= r_map[w_hit_idx];
        end
    end

    assign o_sts.is_free = (r_op == OP_FREE) && r_hit;
    assign o_sts.div_done = w_div_done;

    mpsa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_offs),
        .i_divisor  (r_size),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    // Lowest clear slot of the matched pool.
    always_comb begin
        w_slot_any = 1'b0;
        w_slot     = '0;
        for (int s = SLOTS - 1; s >= 0; s--) begin
            if (!r_pmap[s]) begin
                w_slot_any = 1'b1;
                w_slot     = SI_W'(s);
            end
        end
    end

    // Apply the operation and register the result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            for (int i = 0; i < NUM_POOLS; i++) begin
                r_map[i] <= '0;
            end
        end else if (i_cmd.exec) begin
            r_aoffs <= '0;
            r_status <= ST_OK;
            unique case (r_op)
                OP_CREATE: begin
                    if (r_size == '0 || r_size[1:0] != 2'b00) begin
                        r_status <= ST_BAD_SIZE;
                    end else if (!r_hit) begin
                        if (r_has_free) begin
                            r_valid[r_free_idx] <= 1'b1;
                            r_bytes[r_free_idx] <= r_size;
                            r_map[r_free_idx]   <= '0;
                        end else begin
                            r_status <= ST_TABLE_FULL;
                        end
                    end
                end
                OP_ALLOC: begin
                    if (!r_hit) begin
                        r_status <= ST_NO_POOL;
                    end else if (!w_slot_any) begin
                        r_status <= ST_POOL_FULL;
                    end else begin
                        r_map[r_hit_idx][w_slot] <= 1'b1;
                        r_aoffs <= OFFS_W'({{(32-SI_W){1'b0}}, w_slot} * {16'd0, r_size});
                    end
                end
                OP_FREE: begin
                    if (!r_hit) begin
                        r_status <= ST_NO_POOL;
                    end else if (w_rem != '0 || w_quot >= OFFS_W'(SLOTS)) begin
                        r_status <= ST_BAD_ARG;
                    end else if (!r_pmap[w_quot[SI_W-1:0]]) begin
                        r_status <= ST_BAD_ARG;
                    end else begin
                        r_map[r_hit_idx][w_quot[SI_W-1:0]] <= 1'b0;
                    end
                end
                OP_DESTROY: begin
                    if (!r_hit) begin
                        r_status <= ST_NO_POOL;
                    end else begin
                        r_valid[r_hit_idx] <= 1'b0;
                        r_map[r_hit_idx]   <= '0;
                    end
                end
                default: r_status <= ST_OK;
            endcase
        end
    end

    assign o_status       = r_status;
    assign o_alloc_offset = r_aoffs;

endmodule

>>> rtl/mpsa_ctrl.sv
// Controller state machine that sequences one operation at a time.
module mpsa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    output logic           o_valid,
    output mpsa_pkg::t_cmd o_cmd,
    input  mpsa_pkg::t_sts i_sts
);
    import mpsa_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        busy    = 1'b1;
        o_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (i_sts.is_free) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIVIDE;
                end else begin
                    o_cmd.exec = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DIVIDE: begin
                if (i_sts.div_done) begin
                    o_cmd.exec = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

>>> rtl/multi_pool_slot_allocator_unit.sv
// Create, allocate and destroy step through the lookup and execute states to done, which
// raises o_valid. Free also divides the offset by the pool size, one quotient bit a cycle.
// One operation at a time; busy stays high through the result strobe, so a new word is
// accepted only once the unit is back in idle after the previous result.
// The result is on the outputs for one cycle with o_valid; it cannot be stalled.
// Synchronous active-low reset empties the pool table and all slot bitmaps.
module multi_pool_slot_allocator_unit #(
    parameter int NUM_POOLS = mpsa_pkg::NUM_POOLS_DEF,
    parameter int SLOTS     = mpsa_pkg::SLOTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [mpsa_pkg::OP_W-1:0]   i_op,
    input  logic [mpsa_pkg::SIZE_W-1:0] i_obj_size,
    input  logic [mpsa_pkg::OFFS_W-1:0] i_offset,
    output logic                        o_valid,
    output logic [mpsa_pkg::STAT_W-1:0] o_status,
    output logic [mpsa_pkg::OFFS_W-1:0] o_alloc_offset
);
    import mpsa_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    mpsa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_valid (o_valid),
        .o_cmd   (w_cmd),
        .i_sts   (w_sts)
    );

    mpsa_datapath #(
        .NUM_POOLS (NUM_POOLS),
        .SLOTS     (SLOTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_op           (i_op),
        .i_obj_size     (i_obj_size),
        .i_offset       (i_offset),
        .o_status       (o_status),
        .o_alloc_offset (o_alloc_offset)
    );

endmodule
